### rtl/core/trs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types and constants for the translate-rotate-scale transform unit
// ----------------------------------------------------------------------------
package trs_pkg;

    // component width: vectors Q(W/2).(W/2), quaternions Q1.(W-2)
    localparam int COMPONENT_WIDTH = 16;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int POSITION_W  = 48;
    localparam int ROTATION_W  = 64;
    localparam int SCALE_W     = 48;

    localparam logic [CFG_INDEX_W-1:0] REG_POSITION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROTATION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE    = 2'd2;

    // operations
    typedef enum logic [2:0] {
        OP_POINT            = 3'd0,
        OP_INV_POINT        = 3'd1,
        OP_ROT_DIR          = 3'd2,
        OP_QUAT_COMPOSE     = 3'd3,
        OP_QUAT_INV_COMPOSE = 3'd4,
        OP_SCALE            = 3'd5,
        OP_INV_SCALE        = 3'd6
    } trs_op_t;

    // fault codes
    localparam logic [1:0] FAULT_OK       = 2'd0;
    localparam logic [1:0] FAULT_SAT      = 2'd1;
    localparam logic [1:0] FAULT_DIV_ZERO = 2'd2;

    typedef struct packed {
        logic [2:0]                        opcode;
        logic signed [COMPONENT_WIDTH-1:0] arg_x;
        logic signed [COMPONENT_WIDTH-1:0] arg_y;
        logic signed [COMPONENT_WIDTH-1:0] arg_z;
        logic signed [COMPONENT_WIDTH-1:0] arg_w;
    } trs_in_t;

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] res_x;
        logic signed [COMPONENT_WIDTH-1:0] res_y;
        logic signed [COMPONENT_WIDTH-1:0] res_z;
        logic signed [COMPONENT_WIDTH-1:0] res_w;
        logic [1:0]                        fault;
    } trs_out_t;

endpackage

### rtl/core/trs_quaternion_transform_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_quaternion_transform_unit
// Fixed-point translate-rotate-scale engine: point, direction, quaternion
// and per-axis scale transforms against a configured pose
// ----------------------------------------------------------------------------
// throughput: one transfer per cycle unless a result waits on m_ready, which
//   holds the whole pipe; a restoring divider, one quotient bit per stage,
//   serves the inverse point and inverse scale operations
// reset: synchronous active-low aresetn clears all valid bits and loads
//   identity pose (zero position, unit quaternion, scale 1.0 on every axis)
module trs_quaternion_transform_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [trs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [trs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // operand channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  trs_pkg::trs_in_t                 s_data,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output trs_pkg::trs_out_t                m_data
);
    import trs_pkg::*;

    // ------------------------------------------------------------------
    // widths
    // ------------------------------------------------------------------
    localparam int CW    = COMPONENT_WIDTH;
    localparam int FV    = CW / 2;            // vector fraction bits
    localparam int FQ    = CW - 2;            // quaternion fraction bits
    localparam int QW    = CW + 1;            // quaternion incl. negated min
    localparam int IW    = CW + CW / 2 + 8;   // intermediate vector width
    localparam int PW    = QW + IW;           // product width
    localparam int DW    = CW + 1;            // divisor width (2*|scale|)
    localparam int NW    = IW + FV + 2;       // dividend width
    localparam int QTW   = CW + 1;            // quotient bits kept
    localparam int DEPTH = CW + 1;            // divider stages

    typedef logic signed [IW-1:0] wide_t;
    typedef logic signed [QW-1:0] quat_t;

    localparam longint OUT_MAX_L = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam wide_t  OUT_MAX   = IW'(OUT_MAX_L);
    localparam wide_t  OUT_MIN   = -OUT_MAX - wide_t'(1);

    localparam logic [ROTATION_W-1:0] ROT_RESET = ROTATION_W'(64'd1 << FQ);

    function automatic logic [SCALE_W-1:0] scale_reset();
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < 3; k++) begin
            if (k * CW < 64) begin
                v = v | ((64'd1 << FV) << (k * CW));
            end
        end
        return v[SCALE_W-1:0];
    endfunction

    localparam logic [SCALE_W-1:0] SCALE_RESET = scale_reset();

    // lane k of a packed register; lanes above bit 63 read as zero
    function automatic logic signed [CW-1:0] lane_of(input logic [63:0] r, input int k);
        logic [63:0] sh;
        sh = (k * CW >= 64) ? 64'd0 : (r >> (k * CW));
        return sh[CW-1:0];
    endfunction

    // product shifted right by sh, rounded half away from zero
    function automatic wide_t rmul(input quat_t a, input wide_t b, input int sh);
        logic signed [PW-1:0] p;
        logic [PW-1:0]        m;
        wide_t                r;
        p = PW'(a) * PW'(b);
        m = p[PW-1] ? PW'(-p) : PW'(p);
        m = (m + (PW'(1) << (sh - 1))) >> sh;
        r = IW'(m);
        return p[PW-1] ? -r : r;
    endfunction

    // clamp to component range, flag in the top bit
    function automatic logic [CW:0] clamp_out(input wide_t v);
        if (v > OUT_MAX) begin
            return {1'b1, OUT_MAX[CW-1:0]};
        end else if (v < OUT_MIN) begin
            return {1'b1, OUT_MIN[CW-1:0]};
        end
        return {1'b0, v[CW-1:0]};
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [POSITION_W-1:0] position_reg;
    logic [ROTATION_W-1:0] rotation_reg;
    logic [SCALE_W-1:0]    scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            rotation_reg <= ROT_RESET;
            scale_reg    <= SCALE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_POSITION: position_reg <= cfg_wdata[POSITION_W-1:0];
                REG_ROTATION: rotation_reg <= cfg_wdata[ROTATION_W-1:0];
                REG_SCALE:    scale_reg    <= cfg_wdata[SCALE_W-1:0];
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    // lanes x first; user changes config only while pipe empty, unenforced
    logic signed [CW-1:0] pos_lane [3];
    logic signed [CW-1:0] scl_lane [3];
    logic signed [CW-1:0] rot_lane [4];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_lane[i] = lane_of(64'(position_reg), 2 - i);
            scl_lane[i] = lane_of(64'(scale_reg), 2 - i);
        end
        for (int i = 0; i < 4; i++) begin
            rot_lane[i] = lane_of(rotation_reg, 3 - i);
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: the whole pipe holds while a result waits
    // ------------------------------------------------------------------
    logic advance;
    logic m_valid_reg;
    logic [3:0] pvld_reg;              // stages 1..4
    logic       dvld_reg [DEPTH+1];    // divider prep and bit stages

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvld_reg <= '0;
        end else if (advance) begin
            pvld_reg <= {pvld_reg[2:0], s_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: operand capture, quaternion conjugate, scale or offset
    // ------------------------------------------------------------------
    logic signed [CW-1:0] in_arg [4];
    logic                 conj_sel;
    quat_t                s1_q_next [4];
    wide_t                s1_v_next [3];

    logic [2:0]           s1_op_reg;
    logic signed [CW-1:0] s1_a_reg [4];
    quat_t                s1_q_reg [4];
    wide_t                s1_v_reg [3];

    always_comb begin
        in_arg[0] = s_data.arg_x;
        in_arg[1] = s_data.arg_y;
        in_arg[2] = s_data.arg_z;
        in_arg[3] = s_data.arg_w;
        conj_sel  = (s_data.opcode == OP_INV_POINT) ||
                    (s_data.opcode == OP_QUAT_INV_COMPOSE);
        for (int i = 0; i < 3; i++) begin
            s1_q_next[i] = conj_sel ? -QW'(rot_lane[i]) : QW'(rot_lane[i]);
        end
        s1_q_next[3] = QW'(rot_lane[3]);
        for (int i = 0; i < 3; i++) begin
            case (s_data.opcode)
                OP_POINT, OP_SCALE: s1_v_next[i] = rmul(QW'(scl_lane[i]), IW'(in_arg[i]), FV);
                OP_INV_POINT:       s1_v_next[i] = IW'(in_arg[i]) - IW'(pos_lane[i]);
                default:            s1_v_next[i] = IW'(in_arg[i]);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_op_reg <= s_data.opcode;
            s1_a_reg  <= in_arg;
            s1_q_reg  <= s1_q_next;
            s1_v_reg  <= s1_v_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: first cross product u x v, quaternion product terms
    // ------------------------------------------------------------------
    wide_t s2_uv_next [3];
    wide_t s2_qm_next [4];
    wide_t qa [4][4];                  // qa[i][j] = q[i] * arg[j]

    logic [2:0] s2_op_reg;
    quat_t      s2_q_reg [4];
    wide_t      s2_v_reg [3];
    wide_t      s2_uv_reg [3];
    wide_t      s2_qm_reg [4];

    always_comb begin
        s2_uv_next[0] = rmul(s1_q_reg[1], s1_v_reg[2], FQ) - rmul(s1_q_reg[2], s1_v_reg[1], FQ);
        s2_uv_next[1] = rmul(s1_q_reg[2], s1_v_reg[0], FQ) - rmul(s1_q_reg[0], s1_v_reg[2], FQ);
        s2_uv_next[2] = rmul(s1_q_reg[0], s1_v_reg[1], FQ) - rmul(s1_q_reg[1], s1_v_reg[0], FQ);
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                qa[i][j] = rmul(s1_q_reg[i], IW'(s1_a_reg[j]), FQ);
            end
        end
        // hamilton product, index 3 is w
        s2_qm_next[3] = qa[3][3] - qa[0][0] - qa[1][1] - qa[2][2];
        s2_qm_next[0] = qa[3][0] + qa[0][3] + qa[1][2] - qa[2][1];
        s2_qm_next[1] = qa[3][1] - qa[0][2] + qa[1][3] + qa[2][0];
        s2_qm_next[2] = qa[3][2] + qa[0][1] - qa[1][0] + qa[2][3];
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_op_reg <= s1_op_reg;
            s2_q_reg  <= s1_q_reg;
            s2_v_reg  <= s1_v_reg;
            s2_uv_reg <= s2_uv_next;
            s2_qm_reg <= s2_qm_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: second cross product u x (u x v) and w * (u x v)
    // ------------------------------------------------------------------
    wide_t s3_uuv_next [3];
    wide_t s3_wuv_next [3];

    logic [2:0] s3_op_reg;
    wide_t      s3_v_reg [3];
    wide_t      s3_uuv_reg [3];
    wide_t      s3_wuv_reg [3];
    wide_t      s3_qm_reg [4];

    always_comb begin
        s3_uuv_next[0] = rmul(s2_q_reg[1], s2_uv_reg[2], FQ) - rmul(s2_q_reg[2], s2_uv_reg[1], FQ);
        s3_uuv_next[1] = rmul(s2_q_reg[2], s2_uv_reg[0], FQ) - rmul(s2_q_reg[0], s2_uv_reg[2], FQ);
        s3_uuv_next[2] = rmul(s2_q_reg[0], s2_uv_reg[1], FQ) - rmul(s2_q_reg[1], s2_uv_reg[0], FQ);
        for (int i = 0; i < 3; i++) begin
            s3_wuv_next[i] = rmul(s2_q_reg[3], s2_uv_reg[i], FQ);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s3_op_reg  <= s2_op_reg;
            s3_v_reg   <= s2_v_reg;
            s3_uuv_reg <= s3_uuv_next;
            s3_wuv_reg <= s3_wuv_next;
            s3_qm_reg  <= s2_qm_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: rotation v + 2(w(u x v) + u x (u x v)), translation, select
    // ------------------------------------------------------------------
    wide_t s4_val_next [4];
    wide_t rot_sum [3];
    wide_t rot_vec [3];

    logic [2:0] s4_op_reg;
    wide_t      s4_val_reg [4];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rot_sum[i] = s3_wuv_reg[i] + s3_uuv_reg[i];
            rot_vec[i] = s3_v_reg[i] + (rot_sum[i] <<< 1) +
                         ((s3_op_reg == OP_POINT) ? IW'(pos_lane[i]) : wide_t'(0));
        end
        for (int i = 0; i < 3; i++) begin
            case (s3_op_reg)
                OP_POINT, OP_INV_POINT, OP_ROT_DIR:   s4_val_next[i] = rot_vec[i];
                OP_SCALE, OP_INV_SCALE:               s4_val_next[i] = s3_v_reg[i];
                OP_QUAT_COMPOSE, OP_QUAT_INV_COMPOSE: s4_val_next[i] = s3_qm_reg[i];
                default:                              s4_val_next[i] = '0;
            endcase
        end
        s4_val_next[3] = ((s3_op_reg == OP_QUAT_COMPOSE) ||
                          (s3_op_reg == OP_QUAT_INV_COMPOSE)) ? s3_qm_reg[3] : wide_t'(0);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s4_op_reg  <= s3_op_reg;
            s4_val_reg <= s4_val_next;
        end
    end

    // ------------------------------------------------------------------
    // divider: prep (index 0) then one quotient bit per stage, msb first
    // quotient = floor((2*|n|*2^FV + |s|) / (2*|s|)), rounds half up
    // ------------------------------------------------------------------
    logic [2:0]      dop_reg   [DEPTH+1];
    wide_t           dval_reg  [DEPTH+1][4];
    logic [NW-1:0]   drem_reg  [DEPTH+1][3];
    logic [DW-1:0]   dden_reg  [DEPTH+1][3];
    logic [QTW-1:0]  dquo_reg  [DEPTH+1][3];
    logic [2:0]      dovf_reg  [DEPTH+1];
    logic [2:0]      dneg_reg  [DEPTH+1];
    logic [2:0]      dzero_reg [DEPTH+1];

    logic signed [DW-1:0] prep_scl [3];
    logic [DW-1:0]        prep_us  [3];
    wide_t                prep_un  [3];
    logic [NW-1:0]        prep_num [3];
    logic [DW-1:0]        prep_den [3];
    logic [2:0]           prep_ovf;
    logic [2:0]           prep_neg;
    logic [2:0]           prep_zero;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prep_scl[i]  = DW'(scl_lane[i]);
            prep_us[i]   = prep_scl[i][DW-1] ? DW'(-prep_scl[i]) : DW'(prep_scl[i]);
            prep_un[i]   = s4_val_reg[i][IW-1] ? -s4_val_reg[i] : s4_val_reg[i];
            prep_num[i]  = (NW'(prep_un[i]) << (FV + 1)) + NW'(prep_us[i]);
            prep_den[i]  = prep_us[i] << 1;
            prep_ovf[i]  = prep_num[i] >= (NW'(prep_den[i]) << (CW + 1));
            prep_neg[i]  = s4_val_reg[i][IW-1] ^ scl_lane[i][CW-1];
            prep_zero[i] = (scl_lane[i] == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvld_reg[0] <= 1'b0;
        end else if (advance) begin
            dvld_reg[0] <= pvld_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dop_reg[0]   <= s4_op_reg;
            dval_reg[0]  <= s4_val_reg;
            drem_reg[0]  <= prep_num;
            dden_reg[0]  <= prep_den;
            dquo_reg[0]  <= '{default: '0};
            dovf_reg[0]  <= prep_ovf;
            dneg_reg[0]  <= prep_neg;
            dzero_reg[0] <= prep_zero;
        end
    end

    for (genvar k = 1; k <= DEPTH; k++) begin : g_div
        localparam int BIT = DEPTH - k;    // quotient bit settled here
        logic [NW-1:0]  trial    [3];
        logic [NW-1:0]  rem_next [3];
        logic [QTW-1:0] quo_next [3];

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                trial[l] = NW'(dden_reg[k-1][l]) << BIT;
                quo_next[l] = dquo_reg[k-1][l];
                if (drem_reg[k-1][l] >= trial[l]) begin
                    rem_next[l]      = drem_reg[k-1][l] - trial[l];
                    quo_next[l][BIT] = 1'b1;
                end else begin
                    rem_next[l] = drem_reg[k-1][l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvld_reg[k] <= 1'b0;
            end else if (advance) begin
                dvld_reg[k] <= dvld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                dop_reg[k]   <= dop_reg[k-1];
                dval_reg[k]  <= dval_reg[k-1];
                drem_reg[k]  <= rem_next;
                dden_reg[k]  <= dden_reg[k-1];
                dquo_reg[k]  <= quo_next;
                dovf_reg[k]  <= dovf_reg[k-1];
                dneg_reg[k]  <= dneg_reg[k-1];
                dzero_reg[k] <= dzero_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // output stage: sign, zero-divisor handling, clamp, fault code
    // ------------------------------------------------------------------
    logic     is_div;
    wide_t    div_mag [3];
    wide_t    fin_val [4];
    logic [CW:0] fin_clamp [4];
    logic [3:0]  lane_sat;
    logic        div_zero;
    trs_out_t    out_next;
    trs_out_t    m_data_reg;

    always_comb begin
        is_div = (dop_reg[DEPTH] == OP_INV_POINT) || (dop_reg[DEPTH] == OP_INV_SCALE);
        div_zero = 1'b0;
        lane_sat = '0;
        for (int i = 0; i < 3; i++) begin
            div_mag[i] = dovf_reg[DEPTH][i] ? (wide_t'(1) <<< (CW + 1))
                                            : IW'(dquo_reg[DEPTH][i]);
            if (is_div) begin
                fin_val[i] = dneg_reg[DEPTH][i] ? -div_mag[i] : div_mag[i];
            end else begin
                fin_val[i] = dval_reg[DEPTH][i];
            end
        end
        fin_val[3] = dval_reg[DEPTH][3];
        for (int i = 0; i < 4; i++) begin
            fin_clamp[i] = clamp_out(fin_val[i]);
            lane_sat[i]  = fin_clamp[i][CW];
        end
        // zero scale lane: result zero, no saturation from that lane
        for (int i = 0; i < 3; i++) begin
            if (is_div && dzero_reg[DEPTH][i]) begin
                fin_clamp[i] = '0;
                lane_sat[i]  = 1'b0;
                div_zero     = 1'b1;
            end
        end
        out_next.res_x = fin_clamp[0][CW-1:0];
        out_next.res_y = fin_clamp[1][CW-1:0];
        out_next.res_z = fin_clamp[2][CW-1:0];
        out_next.res_w = fin_clamp[3][CW-1:0];
        if (div_zero) begin
            out_next.fault = FAULT_DIV_ZERO;
        end else if (lane_sat != '0) begin
            out_next.fault = FAULT_SAT;
        end else begin
            out_next.fault = FAULT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= dvld_reg[DEPTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
